[rtl/pdlr_pkg.sv]
`timescale 1ns / 1ps
package pdlr_pkg;
    localparam int RawW   = 32;
    localparam int QW     = 33;
    localparam int SumW   = 36;
    localparam int PhaseW = 35;
    localparam int StepW  = 35;
    localparam logic [StepW-1:0] MinStep = 35'd715827883;
    localparam logic [PhaseW-1:0] OneQ32 = 35'h1_0000_0000;
    localparam logic signed [QW-1:0] FullScale = 33'sd2147418112;
    localparam logic signed [QW-1:0] NegScale  = -33'sd2147483648;

    typedef enum logic [1:0] {
        FMT_PCM16 = 2'd0,
        FMT_PCM24 = 2'd1,
        FMT_PCM32 = 2'd2,
        FMT_FLOAT = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_CHANNELS = 2'd1,
        REG_STEP = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;
endpackage

[rtl/pcm_downmix_linear_resampler_unit.sv]
`timescale 1ns / 1ps
// From frame transfer to first sample: one lane stage, then a 35-step
// restoring divide for the channel average; each emitted sample then takes a
// phase test, a registered multiply and the output register. A frame emits
// 0..6 samples, and no new frame is taken until its walk ends; the bit-serial
// divider sets the pace, and a stalled sample holds the walk. Reset (aresetn low,
// synchronous) clears phase, previous mono and the registers to pcm16, one channel, unit step.
module pcm_downmix_linear_resampler_unit import pdlr_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [34:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_chan0_raw,
    input  logic [31:0]        s_chan1_raw,
    input  logic [31:0]        s_chan2_raw,
    input  logic [31:0]        s_chan3_raw,
    input  logic [31:0]        s_chan4_raw,
    input  logic [31:0]        s_chan5_raw,
    input  logic [31:0]        s_chan6_raw,
    input  logic [31:0]        s_chan7_raw,
    input  logic               s_silent,
    input  logic               s_buffer_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mono_sample,
    output logic               m_last_of_run
);
    logic [RawW-1:0] raw_in [8];
    logic signed [QW-1:0] lane_q [MAX_CHANNELS];
    logic [3:0] eff_cnt;

    fmt_t             fmt_reg;
    logic [3:0]       cnt_reg;
    logic [StepW-1:0] step_reg;
    state_t           state_reg, state_next;
    // One spare bit: the cursor may pass 2^35 during a walk before the wrap.
    logic [PhaseW:0]  phase_reg, phase_next;
    logic signed [QW-1:0] prev_reg, prev_next;
    logic signed [QW-1:0] cur_reg, cur_next;
    logic             silent_reg;
    logic [QW-1:0]    dmag_reg, dmag_next;
    logic             dneg_reg, dneg_next;
    logic [QW+31:0]   prod_reg;
    logic signed [15:0] out_s_reg, out_s_next;
    logic             out_l_reg, out_l_next;
    logic             mv_reg, mv_next;
    logic             start;
    logic             start_d_reg;
    logic             div_done;
    logic signed [QW-1:0] mono;
    logic [StepW-1:0] step_eff;
    logic signed [QW:0] v;
    logic [QW-1:0]    p;
    logic [PhaseW:0]  phase_adv;
    logic signed [QW:0] diff;

    assign raw_in[0] = s_chan0_raw;
    assign raw_in[1] = s_chan1_raw;
    assign raw_in[2] = s_chan2_raw;
    assign raw_in[3] = s_chan3_raw;
    assign raw_in[4] = s_chan4_raw;
    assign raw_in[5] = s_chan5_raw;
    assign raw_in[6] = s_chan6_raw;
    assign raw_in[7] = s_chan7_raw;

    // Clamp the channel count into 1..MAX_CHANNELS.
    always_comb begin
        if (cnt_reg == 4'd0) begin
            eff_cnt = 4'd1;
        end else if (cnt_reg > 4'(MAX_CHANNELS)) begin
            eff_cnt = 4'(MAX_CHANNELS);
        end else begin
            eff_cnt = cnt_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign start     = s_valid && s_ready;

    // One lane per channel; lanes beyond the count contribute zero.
    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
        pdlr_lane u_lane (
            .aclk   (aclk),
            .load   (start),
            .fmt    (fmt_reg),
            .raw    (raw_in[g]),
            .enable (4'(g) < eff_cnt),
            .q_reg  (lane_q[g])
        );
    end

    // Start the average in the cycle after the transfer, once the lanes hold.
    pdlr_merge #(.Lanes(MAX_CHANNELS)) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_d_reg),
        .lane_q  (lane_q),
        .count   (eff_cnt),
        .done    (div_done),
        .mono    (mono)
    );

    assign step_eff = (step_reg < MinStep) ? MinStep : step_reg;
    assign phase_adv = phase_reg + {1'b0, step_eff};

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        dmag_next  = dmag_reg;
        dneg_next  = dneg_reg;
        out_s_next = out_s_reg;
        out_l_next = out_l_reg;
        mv_next    = mv_reg;
        diff       = {cur_reg[QW-1], cur_reg} - {prev_reg[QW-1], prev_reg};
        p          = prod_reg[QW+31:32];
        v          = dneg_reg ? ({prev_reg[QW-1], prev_reg} - {1'b0, p})
                              : ({prev_reg[QW-1], prev_reg} + {1'b0, p});
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    cur_next   = silent_reg ? '0 : mono;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // Walk the phase: one sample per visit while phase < 1.
                if (!mv_next) begin
                    if (phase_reg < {1'b0, OneQ32}) begin
                        dneg_next  = diff[QW];
                        dmag_next  = diff[QW] ? QW'(-diff) : QW'(diff);
                        state_next = ST_MUL;
                    end else begin
                        phase_next = phase_reg - {1'b0, OneQ32};
                        prev_next  = cur_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (silent_reg) begin
                    out_s_next = '0;
                end else if (v >= $signed({FullScale[QW-1], FullScale})) begin
                    out_s_next = 16'sd32767;
                end else if (v <= $signed({NegScale[QW-1], NegScale})) begin
                    out_s_next = -16'sd32768;
                end else if (v[QW]) begin
                    out_s_next = -$signed(16'((-v) >>> 16));
                end else begin
                    out_s_next = 16'(v >>> 16);
                end
                out_l_next = (phase_adv >= {1'b0, OneQ32});
                mv_next    = 1'b1;
                phase_next = phase_adv;
                state_next = ST_WAIT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fmt_reg     <= FMT_PCM16;
            cnt_reg     <= 4'd1;
            step_reg    <= OneQ32;
            phase_reg   <= '0;
            prev_reg    <= '0;
            mv_reg      <= 1'b0;
            start_d_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            mv_reg      <= mv_next;
            start_d_reg <= start;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FORMAT:   fmt_reg  <= fmt_t'(cfg_data[1:0]);
                    REG_CHANNELS: cnt_reg  <= cfg_data[3:0];
                    REG_STEP:     step_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (start) begin
            silent_reg <= s_silent;
        end
        cur_reg   <= cur_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        prod_reg  <= {32'd0, dmag_reg} * {{QW{1'b0}}, phase_reg[31:0]};
        out_s_reg <= out_s_next;
        out_l_reg <= out_l_next;
    end

    assign m_valid       = mv_reg;
    assign m_mono_sample = out_s_reg;
    assign m_last_of_run = out_l_reg;
endmodule

[rtl/pdlr_lane.sv]
`timescale 1ns / 1ps
// Convert one raw word to Q16.16, registered.
module pdlr_lane import pdlr_pkg::*; (
    input  logic                  aclk,
    input  logic                  load,
    input  fmt_t                  fmt,
    input  logic [RawW-1:0]       raw,
    input  logic                  enable,
    output logic signed [QW-1:0]  q_reg
);
    logic signed [QW-1:0] q_next;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [39:0] prod;
    logic [7:0]  sh;
    logic [QW-1:0] mag;

    always_comb begin
        ex   = raw[30:23];
        man  = {(ex != 8'd0), raw[22:0]};
        prod = {16'd0, man} * 40'd32767;
        sh   = (ex == 8'd0) ? 8'd133 : (8'd134 - ex);
        mag  = '0;
        if (ex >= 8'd127) begin
            mag = FullScale;
        end else if (sh < 8'd40) begin
            mag = QW'(prod >> sh);
        end
        q_next = '0;
        if (enable) begin
            case (fmt)
                FMT_PCM16: q_next = {raw[15], raw[15:0], 16'd0};
                FMT_PCM24: q_next = {{(QW-32){raw[23]}}, raw[23:0], 8'd0};
                FMT_PCM32: q_next = {raw[31], raw};
                default: begin
                    if (ex == 8'hFF && raw[22:0] != 23'd0) begin
                        q_next = '0;
                    end else if (raw[31]) begin
                        q_next = -$signed(mag);
                    end else begin
                        q_next = $signed(mag);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end
endmodule

[rtl/pdlr_merge.sv]
`timescale 1ns / 1ps
// Sum the lanes; divide the magnitude by the count one bit per cycle.
module pdlr_merge import pdlr_pkg::*; #(
    parameter int Lanes = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [QW-1:0]        lane_q [Lanes],
    input  logic [3:0]                  count,
    output logic                        done,
    output logic signed [QW-1:0]        mono
);
    localparam int MagW = SumW - 1;
    localparam int CntW = $clog2(MagW + 1);
    logic signed [SumW-1:0] sum;
    logic [MagW-1:0] quot_reg, quot_next;
    logic [4:0]      rem_reg, rem_next;
    logic [4:0]      rem_sh;
    logic            neg_reg, neg_next;
    logic [CntW-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [MagW-1:0] smag;

    always_comb begin
        sum = '0;
        for (int i = 0; i < Lanes; i++) begin
            sum = sum + SumW'(lane_q[i]);
        end
        smag = sum[SumW-1] ? MagW'(-sum) : MagW'(sum);
        quot_next = quot_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[3:0], quot_reg[MagW-1]};
        if (start) begin
            quot_next = smag;
            rem_next  = '0;
            neg_next  = sum[SumW-1];
            bit_next  = CntW'(MagW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, count}) begin
                rem_next  = rem_sh - {1'b0, count};
                quot_next = {quot_reg[MagW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[MagW-2:0], 1'b0};
            end
            bit_next = bit_reg - 1'b1;
            if (bit_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign mono = neg_reg ? -$signed(QW'(quot_reg)) : $signed(QW'(quot_reg));
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import pdlr_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;  // index with no register behind it
    localparam int HALF_PERIOD = 4;
    localparam int SETTLE_CYCLES = 80;         // margin for a frame without output to finish
    localparam longint FULL_Q16 = 64'sd32767 * 65536;
    localparam longint NEG_Q16 = -64'sd32768 * 65536;
    localparam longint ONE_PHASE = 64'd1 << 32;
    localparam longint MAX_STEP = (64'd1 << 35) - 1;

    typedef struct {
        logic [31:0] raw [8];
        logic        silent;
        logic        buffer_end;
    } frame_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } mono_out_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [34:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_chan_raw [8];
    logic               s_silent = 1'b0;
    logic               s_buffer_end = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_mono_sample;
    logic               m_last_of_run;

    // Shadow of the block: registers and the resampler state.
    logic [1:0]  shadow_fmt = FMT_PCM16;
    logic [3:0]  shadow_chans = 4'd1;
    logic [34:0] shadow_step = 35'h1_0000_0000;
    longint      resamp_phase = 0;
    longint      resamp_prev = 0;

    frame_t    frames_pending [$];
    mono_out_t samples_due [$];

    int errors = 0;
    int frames_taken = 0;
    int samples_seen = 0;
    int silent_taken = 0;
    int empty_frames = 0;
    int phases_run = 0;

    // Config channel requests from the sequence.
    logic        cfg_go = 1'b0;
    logic        cfg_busy = 1'b0;
    logic [1:0]  cfg_req_index;
    logic [34:0] cfg_req_data;

    initial begin
        for (int i = 0; i < 8; i++) s_chan_raw[i] = '0;
    end

    always #HALF_PERIOD aclk = ~aclk;

    pcm_downmix_linear_resampler_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_chan0_raw   (s_chan_raw[0]),
        .s_chan1_raw   (s_chan_raw[1]),
        .s_chan2_raw   (s_chan_raw[2]),
        .s_chan3_raw   (s_chan_raw[3]),
        .s_chan4_raw   (s_chan_raw[4]),
        .s_chan5_raw   (s_chan_raw[5]),
        .s_chan6_raw   (s_chan_raw[6]),
        .s_chan7_raw   (s_chan_raw[7]),
        .s_silent      (s_silent),
        .s_buffer_end  (s_buffer_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mono_sample (m_mono_sample),
        .m_last_of_run (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Sample conversion and resampling, mirrored in 64-bit arithmetic.
    // ------------------------------------------------------------------

    // Float word to Q16.16: clamp to +-1, scale by 32767, truncate magnitude.
    function automatic longint float_to_fixed(logic [31:0] w);
        logic [7:0]  ex;
        logic [63:0] man;
        logic [63:0] mag;
        int          sh;
        ex = w[30:23];
        man = {41'd0, w[22:0]};
        if (ex == 8'hFF && man != 0) return 0;  // NaN counts as zero
        if (ex >= 8'd127) begin
            mag = FULL_Q16;                     // |f| >= 1 and infinities saturate
        end else begin
            if (ex == 0) begin
                sh = 133;                       // denormal: no hidden bit
            end else begin
                man = man | 64'h80_0000;
                sh = 134 - ex;
            end
            mag = (sh < 64) ? ((man * 64'd32767) >> sh) : 64'd0;
        end
        return w[31] ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint word_to_fixed(logic [31:0] w);
        longint v;
        case (shadow_fmt)
            FMT_PCM16: begin
                v = longint'($signed(w[15:0]));
                return v * 65536;
            end
            FMT_PCM24: begin
                v = longint'($signed(w[23:0]));
                return v * 256;
            end
            FMT_PCM32: return longint'($signed(w));
            default:   return float_to_fixed(w);
        endcase
    endfunction

    // Channel average, truncated toward zero.
    function automatic longint downmix(const ref frame_t f);
        int          n;
        longint      sum;
        logic [63:0] mag;
        n = shadow_chans;
        if (n == 0) n = 1;
        if (n > 8) n = 8;
        sum = 0;
        for (int i = 0; i < n; i++) sum += word_to_fixed(f.raw[i]);
        mag = (sum < 0) ? -sum : sum;
        mag = mag / n;
        return (sum < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [15:0] interp_sample(longint s0, longint s1,
                                                         logic [63:0] frac);
        longint      d;
        longint      v;
        logic [63:0] mag;
        logic [63:0] p;
        d = s1 - s0;
        mag = (d < 0) ? -d : d;
        p = (mag * frac) >> 32;  // stays below 2^64, so it matches the block's 65-bit multiply
        v = (d < 0) ? s0 - longint'(p) : s0 + longint'(p);
        if (v >= FULL_Q16) return 16'sh7FFF;
        if (v <= NEG_Q16) return 16'sh8000;
        if (v < 0) return -16'(longint'(64'(-v) >> 16));
        return 16'(longint'(64'(v) >> 16));
    endfunction

    // Walk the phase cursor across one frame interval; queue the samples.
    task automatic resample_frame(const ref frame_t f);
        longint    cur;
        longint    step;
        int        n;
        mono_out_t o;
        step = (shadow_step < MinStep) ? MinStep : shadow_step;
        cur = f.silent ? 0 : downmix(f);
        n = 0;
        while (resamp_phase < ONE_PHASE && n < 6) begin
            o.sample = f.silent ? 16'sd0 : interp_sample(resamp_prev, cur, resamp_phase);
            o.last = 1'b0;
            samples_due.push_back(o);
            n++;
            resamp_phase += step;
        end
        if (n > 0) samples_due[$].last = 1'b1;
        else empty_frames++;
        resamp_phase = (resamp_phase - ONE_PHASE) & MAX_STEP;
        resamp_prev = cur;
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Config driver: one write per request, applied to the shadow on transfer.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FORMAT:   shadow_fmt = cfg_data[1:0];
                REG_CHANNELS: shadow_chans = cfg_data[3:0];
                REG_STEP:     shadow_step = cfg_data;
                default:      ;  // unknown index: drop
            endcase
            cfg_valid <= 1'b0;
            cfg_busy = 1'b0;
        end else if (!cfg_valid && cfg_go) begin
            cfg_index <= cfg_req_index;
            cfg_data <= cfg_req_data;
            cfg_valid <= 1'b1;
            cfg_go = 1'b0;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [34:0] value);
        cfg_req_index = idx;
        cfg_req_data = value;
        cfg_busy = 1'b1;
        cfg_go = 1'b1;
        wait (!cfg_busy);
    endtask

    // ------------------------------------------------------------------
    // Frame driver: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        frame_t f;
        logic   take;
        take = s_valid && s_ready;
        if (take) begin
            f.silent = s_silent;
            f.buffer_end = s_buffer_end;
            for (int i = 0; i < 8; i++) f.raw[i] = s_chan_raw[i];
            resample_frame(f);
            frames_taken++;
            if (s_silent) silent_taken++;
        end
        if (aresetn && (!s_valid || take)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (frames_pending.size() > 0) begin
                f = frames_pending.pop_front();
                for (int i = 0; i < 8; i++) s_chan_raw[i] <= f.raw[i];
                s_silent <= f.silent;
                s_buffer_end <= f.buffer_end;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // End this burst; pick the next gap and burst length.
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver backpressure: alternate stretches of free flow and random
    // stalls, plus one long hold-off so the block fills and stalls its input.
    // ------------------------------------------------------------------
    int  stretch_left = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    logic held_once = 1'b0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && frames_taken >= 200) begin
            held_once = 1'b1;
            hold_left = 600;
            m_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            stretch_left--;
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each sample transfer with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        mono_out_t want;
        if (aresetn && m_valid && m_ready) begin
            samples_seen++;
            if (samples_due.size() == 0) begin
                errors++;
                $display("unexpected sample %0d at %0t", m_mono_sample, $time);
            end else begin
                want = samples_due.pop_front();
                if (m_mono_sample !== want.sample)
                    report("mono_sample", m_mono_sample, want.sample);
                if (m_last_of_run !== want.last)
                    report("last_of_run", m_last_of_run, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Raw word biased toward values that matter for each sample format.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return {16'($urandom_range(0, 65535)), 16'h7FFF};
            1: return {16'($urandom_range(0, 65535)), 16'h8000};
            2: return {8'($urandom_range(0, 255)), 24'h7F_FFFF};
            3: return {8'($urandom_range(0, 255)), 24'h80_0000};
            4: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            5: return {1'($urandom), 8'($urandom_range(100, 130)), 23'($urandom)};
            6: begin
                // float specials: NaN, infinity, denormal, exact one
                case ($urandom_range(0, 3))
                    0: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
                    1: return {1'($urandom), 8'hFF, 23'd0};
                    2: return {1'($urandom), 8'h00, 23'($urandom)};
                    default: return {1'($urandom), 8'h7F, 23'd0};
                endcase
            end
            7: return 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        for (int i = 0; i < 8; i++) f.raw[i] = pick_word();
        f.silent = ($urandom_range(0, 7) == 0);
        f.buffer_end = 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic frame_t flat_frame(logic [31:0] w, logic silent_bit);
        frame_t f;
        for (int i = 0; i < 8; i++) f.raw[i] = w;
        f.silent = silent_bit;
        f.buffer_end = silent_bit;
        return f;
    endfunction

    // Wait for the block to drain, including frames that emit nothing.
    task automatic wait_idle();
        wait (frames_pending.size() == 0 && !s_valid && samples_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(fmt_t fmt, logic [3:0] chans, logic [34:0] step, int count);
        write_reg(REG_FORMAT, 35'(fmt));
        write_reg(REG_CHANNELS, 35'(chans));
        write_reg(REG_STEP, step);
        for (int i = 0; i < count; i++) frames_pending.push_back(rand_frame());
        wait_idle();
        phases_run++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] specials [12];
        specials = '{32'h0000_7FFF, 32'hFFFF_8000, 32'h007F_FFFF, 32'h0080_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0000,
                     32'hFF80_0000, 32'h0000_0001, 32'h3F80_0000, 32'hBF00_0000};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: pcm16 extremes, silence, and a constant level.
        frames_pending.push_back(flat_frame(32'h0000_7FFF, 1'b0));
        frames_pending.push_back(flat_frame(32'h0000_8000, 1'b0));
        frames_pending.push_back(flat_frame(32'hFFFF_FFFF, 1'b1));
        frames_pending.push_back(flat_frame(32'h1234_7FFF, 1'b0));
        frames_pending.push_back(flat_frame(32'h0000_0000, 1'b0));
        wait_idle();

        // Float specials over three channels at the shortest allowed step.
        write_reg(REG_FORMAT, 35'(FMT_FLOAT));
        write_reg(REG_CHANNELS, 35'd3);
        write_reg(REG_STEP, MinStep);
        foreach (specials[i]) frames_pending.push_back(flat_frame(specials[i], 1'b0));
        frames_pending.push_back(flat_frame(32'h3F80_0000, 1'b1));
        wait_idle();

        // An unknown register index must leave every setting alone.
        write_reg(REG_UNUSED, 35'h7_FFFF_FFFF);
        frames_pending.push_back(flat_frame(32'h3F00_0000, 1'b0));
        frames_pending.push_back(flat_frame(32'hBF80_0000, 1'b0));
        wait_idle();
        phases_run++;

        run_phase(FMT_PCM16, 4'd1, 35'h1_0000_0000, 40);
        run_phase(FMT_PCM24, 4'd2, 35'h1_8000_0000, 40);
        run_phase(FMT_PCM32, 4'd8, MinStep, 45);
        run_phase(FMT_FLOAT, 4'd0, 35'd5, 45);                   // step below minimum
        run_phase(FMT_FLOAT, 4'd15, 35'h7_FFFF_FFFF, 45);        // most frames emit nothing
        run_phase(FMT_PCM16, 4'd4, 35'h0_8000_0000, 40);
        run_phase(FMT_PCM24, 4'd1, 35'h4_0000_0000, 40);
        run_phase(FMT_PCM32, 4'd5, 35'($urandom_range(715827883, 32'hFFFF_FFFF)), 45);

        $display("Covered %0d setting phases: %0d frames (%0d silent, %0d without output),",
                 phases_run, frames_taken, silent_taken, empty_frames);
        $display("%0d resampled outputs checked, %0d mismatches.", samples_seen, errors);
        if (errors == 0 && samples_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end
endmodule
